>>> hdl/btd_pkg.sv
package btd_pkg;

	localparam int TILE_W       = 64;
	localparam int TILE_H       = 16;
	localparam int MAX_TILES    = 64;
	localparam int PANO_H_LIMIT = 4096;

	// width of the shared adder: region end plus border and alignment stays below 2^14
	localparam int AW = 15;

	localparam logic [1:0] REG_PANO_WIDTH  = 2'd0;
	localparam logic [1:0] REG_PANO_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BAND_COUNT  = 2'd2;

	typedef struct packed {
		logic [AW-1:0] res;
		logic          borrow;
	} alu_res_t;

	typedef struct packed {
		logic [5:0] last_col;
		logic       edge_h;
		logic       last;
	} tile_info_t;

endpackage

>>> hdl/btd_if.sv
interface btd_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  level;
	logic [4:0]  camera_index;
	logic [12:0] region_left;
	logic [12:0] region_top;
	logic [12:0] region_right;
	logic [12:0] region_bottom;
	logic [7:0]  tile_row;

	modport source (output valid, level, camera_index, region_left, region_top,
		region_right, region_bottom, tile_row, input ready);
	modport sink (input valid, level, camera_index, region_left, region_top,
		region_right, region_bottom, tile_row, output ready);
endinterface

interface btd_tile_if;
	logic        valid;
	logic        ready;
	logic [4:0]  tile_camera;
	logic [11:0] tile_x;
	logic [11:0] tile_y;
	logic [5:0]  last_col;
	logic [3:0]  last_row;
	logic [3:0]  skip_cols;
	logic        edge_horizontal;
	logic        edge_vertical;
	logic        last_tile;

	modport source (output valid, tile_camera, tile_x, tile_y, last_col, last_row,
		skip_cols, edge_horizontal, edge_vertical, last_tile, input ready);
	modport sink (input valid, tile_camera, tile_x, tile_y, last_col, last_row,
		skip_cols, edge_horizontal, edge_vertical, last_tile, output ready);
endinterface

interface btd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [12:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/btd_alu.sv
module btd_alu (
	input  logic [btd_pkg::AW-1:0] a,
	input  logic [btd_pkg::AW-1:0] b,
	input  logic                   sub,
	output btd_pkg::alu_res_t      y
);

	logic [btd_pkg::AW:0] sum;

	// a - b as a + ~b + 1; carry out set means no borrow
	assign sum = {1'b0, a} + {1'b0, b ^ {btd_pkg::AW{sub}}}
		+ {{btd_pkg::AW{1'b0}}, sub};

	assign y.res    = sum[btd_pkg::AW-1:0];
	assign y.borrow = sub ? ~sum[btd_pkg::AW] : sum[btd_pkg::AW];

endmodule

>>> hdl/btd_desc.sv
module btd_desc #(
	parameter int XW = 13
) (
	input  logic [XW-1:0]        x,
	input  logic [XW-1:0]        ex,
	input  logic [XW-1:0]        wl,
	input  logic [5:0]           n,
	output logic [XW-1:0]        next_x,
	output btd_pkg::tile_info_t  info
);

	logic [XW-1:0] d;
	logic          wide;

	// x is below ex whenever a descriptor is formed
	assign d      = ex - x;
	assign wide   = d > XW'(btd_pkg::TILE_W);
	assign next_x = x + XW'(btd_pkg::TILE_W);

	assign info.last_col = wide ? 6'(btd_pkg::TILE_W - 1) : 6'(d - 1'b1);
	// wl is the panorama width scaled to the level, rounded up
	assign info.edge_h   = (x == '0) || (next_x >= wl);
	assign info.last     = !wide || (n == 6'(btd_pkg::MAX_TILES - 1));

endmodule

>>> hdl/blend_tile_descriptor_generator.sv
// channel | dir | content                                   | transfer when
// cfg     | in  | register index, 13-bit data               | cfg.valid && cfg.ready
// req     | in  | level, camera, padded region, tile row    | req.valid && req.ready
// tile    | out | one 64x16 tile descriptor                 | tile.valid && tile.ready
//
// A request runs its setup on the one shared adder (grow, align, clip and
// scale both axes, row check, edge limits), then gives one descriptor per
// cycle unless tile is stalled, from a small per-tile stage: up to 64 per request.
// A row beyond the region ends at the row check with no descriptor.
// req.ready is high only between requests; cfg.ready is always high.
// Reset (arst_n low) restores the register defaults and empties the output register.
// A stalled tile channel holds the descriptor and pauses the tile loop.
module blend_tile_descriptor_generator #(
	parameter int MAX_PANO_WIDTH = 4096
) (
	input logic        clk,
	input logic        arst_n,
	btd_cfg_if.sink    cfg,
	btd_req_if.sink    req,
	btd_tile_if.source tile
);

	localparam int XW = $clog2(MAX_PANO_WIDTH + btd_pkg::TILE_W);
	localparam int AW = btd_pkg::AW;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SX   = 4'd1;
	localparam logic [3:0] ST_EX0  = 4'd2;
	localparam logic [3:0] ST_EX1  = 4'd3;
	localparam logic [3:0] ST_EX2  = 4'd4;
	localparam logic [3:0] ST_SY   = 4'd5;
	localparam logic [3:0] ST_EY0  = 4'd6;
	localparam logic [3:0] ST_EY1  = 4'd7;
	localparam logic [3:0] ST_EY2  = 4'd8;
	localparam logic [3:0] ST_Y    = 4'd9;
	localparam logic [3:0] ST_CH   = 4'd10;
	localparam logic [3:0] ST_WL   = 4'd11;
	localparam logic [3:0] ST_HL   = 4'd12;
	localparam logic [3:0] ST_EV   = 4'd13;
	localparam logic [3:0] ST_XC   = 4'd14;
	localparam logic [3:0] ST_EMIT = 4'd15;

	logic [3:0]  state_q;

	logic [12:0] pano_width_q;
	logic [12:0] pano_height_q;
	logic [3:0]  band_count_q;

	logic [2:0]  level_q;
	logic [4:0]  cam_q;
	logic [12:0] left_q;
	logic [12:0] top_q;
	logic [12:0] right_q;
	logic [12:0] bottom_q;
	logic [7:0]  row_q;

	logic [AW-1:0] e_q;
	logic [12:0]   sx_q;
	logic [XW-1:0] ex_q;
	logic [12:0]   sy_q;
	logic [12:0]   ey_q;
	logic [11:0]   y_q;
	logic [XW-1:0] wl_q;
	logic [3:0]    ch_q;
	logic          edge_v_q;
	logic [3:0]    skip_q;
	logic [XW-1:0] x_q;
	logic [5:0]    n_q;

	logic          o_valid_q;
	logic [4:0]    o_cam_q;
	logic [11:0]   o_x_q;
	logic [11:0]   o_y_q;
	logic [5:0]    o_last_col_q;
	logic [3:0]    o_last_row_q;
	logic [3:0]    o_skip_q;
	logic          o_edge_h_q;
	logic          o_edge_v_q;
	logic          o_last_q;

	logic [2:0]    bm1;
	logic [AW-1:0] align;
	logic [AW-1:0] border;
	logic [AW-1:0] bam1;
	logic [AW-1:0] mask;
	logic [AW-1:0] ru;
	logic [12:0]   w_eff;
	logic [12:0]   h_eff;
	logic [AW-1:0] w15;
	logic [AW-1:0] h15;
	logic [12:0]   sx_raw;
	logic [12:0]   x_start;

	logic [AW-1:0]       alu_a;
	logic [AW-1:0]       alu_b;
	logic                alu_sub;
	btd_pkg::alu_res_t   alu_y;
	logic [XW-1:0]       next_x;
	btd_pkg::tile_info_t info;
	logic                take;

	assign bm1    = (band_count_q == 4'd0) ? 3'd0 :
		(band_count_q > 4'd8) ? 3'd7 : 3'(band_count_q - 4'd1);
	assign align  = AW'(1) << bm1;
	assign border = align << 1;
	assign bam1   = border + align - AW'(1);
	assign mask   = ~(align - AW'(1));
	assign ru     = (AW'(1) << level_q) - AW'(1);

	assign w_eff = (pano_width_q > 13'(MAX_PANO_WIDTH)) ? 13'(MAX_PANO_WIDTH) : pano_width_q;
	assign h_eff = (pano_height_q > 13'(btd_pkg::PANO_H_LIMIT)) ?
		13'(btd_pkg::PANO_H_LIMIT) : pano_height_q;
	assign w15   = AW'(w_eff);
	assign h15   = AW'(h_eff);

	assign sx_raw  = alu_y.borrow ? 13'd0 : alu_y.res[12:0];
	assign x_start = sx_q & ~13'd15;

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			ST_SX: begin
				alu_a   = AW'(left_q);
				alu_b   = border;
				alu_sub = 1'b1;
			end
			ST_EX0: begin
				alu_a = AW'(right_q);
				alu_b = bam1;
			end
			ST_EX1, ST_EY1: begin
				alu_a   = (state_q == ST_EX1) ? w15 : h15;
				alu_b   = e_q;
				alu_sub = 1'b1;
			end
			ST_EX2, ST_EY2: begin
				alu_a = e_q;
				alu_b = ru;
			end
			ST_SY: begin
				alu_a   = AW'(top_q);
				alu_b   = border;
				alu_sub = 1'b1;
			end
			ST_EY0: begin
				alu_a = AW'(bottom_q);
				alu_b = bam1;
			end
			ST_Y: begin
				alu_a = AW'(sy_q);
				alu_b = AW'({row_q, 4'b0000});
			end
			ST_CH: begin
				alu_a   = AW'(ey_q);
				alu_b   = e_q;
				alu_sub = 1'b1;
			end
			ST_WL: begin
				alu_a = w15;
				alu_b = ru;
			end
			ST_HL: begin
				alu_a = h15;
				alu_b = ru;
			end
			ST_EV: begin
				alu_a   = e_q;
				alu_b   = AW'(y_q);
				alu_sub = 1'b1;
			end
			ST_XC: begin
				alu_a   = AW'(ex_q);
				alu_b   = AW'(x_start);
				alu_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	btd_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.y   (alu_y)
	);

	btd_desc #(
		.XW (XW)
	) u_desc (
		.x      (x_q),
		.ex     (ex_q),
		.wl     (wl_q),
		.n      (n_q),
		.next_x (next_x),
		.info   (info)
	);

	assign take = !o_valid_q || tile.ready;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pano_width_q  <= 13'd4096;
			pano_height_q <= 13'd2048;
			band_count_q  <= 4'd4;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				btd_pkg::REG_PANO_WIDTH:  pano_width_q  <= cfg.data;
				btd_pkg::REG_PANO_HEIGHT: pano_height_q <= cfg.data;
				btd_pkg::REG_BAND_COUNT:  band_count_q  <= cfg.data[3:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			o_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && take) begin
				o_valid_q <= 1'b1;
			end else if (tile.ready) begin
				o_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) state_q <= ST_SX;
				end
				ST_CH: begin
					// empty row: the scaled start row plus the tile row offset is at or past the end
					if (alu_y.borrow || alu_y.res == '0) state_q <= ST_IDLE;
					else state_q <= ST_WL;
				end
				ST_XC: begin
					if (alu_y.borrow || alu_y.res == '0) state_q <= ST_IDLE;
					else state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (take && info.last) state_q <= ST_IDLE;
				end
				default: state_q <= state_q + 4'd1;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			level_q  <= req.level;
			cam_q    <= req.camera_index;
			left_q   <= req.region_left;
			top_q    <= req.region_top;
			right_q  <= req.region_right;
			bottom_q <= req.region_bottom;
			row_q    <= req.tile_row;
		end
		case (state_q)
			ST_SX: sx_q <= 13'((sx_raw & mask[12:0]) >> level_q);
			ST_EX0, ST_EY0: e_q <= alu_y.res & mask;
			ST_EX1: begin
				if (alu_y.borrow) e_q <= w15;
			end
			ST_EY1: begin
				if (alu_y.borrow) e_q <= h15;
			end
			ST_EX2: ex_q <= XW'(alu_y.res >> level_q);
			ST_SY: sy_q <= 13'((sx_raw & mask[12:0]) >> level_q);
			ST_EY2: ey_q <= 13'(alu_y.res >> level_q);
			ST_Y: e_q <= alu_y.res;
			ST_CH: begin
				ch_q <= (alu_y.res > AW'(btd_pkg::TILE_H)) ? 4'(btd_pkg::TILE_H - 1) :
					4'(alu_y.res - AW'(1));
				y_q  <= e_q[11:0];
			end
			ST_WL: wl_q <= XW'(alu_y.res >> level_q);
			ST_HL: e_q <= alu_y.res >> level_q;
			ST_EV: begin
				// y + 16 reaches the scaled height when that height minus y is 16 or less
				edge_v_q <= (y_q == 12'd0) || alu_y.borrow || (alu_y.res <= AW'(btd_pkg::TILE_H));
			end
			ST_XC: begin
				x_q    <= XW'(x_start);
				n_q    <= 6'd0;
				skip_q <= sx_q[3:0];
			end
			ST_EMIT: begin
				if (take) begin
					o_cam_q      <= cam_q;
					o_x_q        <= 12'(x_q);
					o_y_q        <= y_q;
					o_last_col_q <= info.last_col;
					o_last_row_q <= ch_q;
					o_skip_q     <= (n_q == 6'd0) ? skip_q : 4'd0;
					o_edge_h_q   <= info.edge_h;
					o_edge_v_q   <= edge_v_q;
					o_last_q     <= info.last;
					x_q          <= next_x;
					n_q          <= n_q + 6'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign tile.valid           = o_valid_q;
	assign tile.tile_camera     = o_cam_q;
	assign tile.tile_x          = o_x_q;
	assign tile.tile_y          = o_y_q;
	assign tile.last_col        = o_last_col_q;
	assign tile.last_row        = o_last_row_q;
	assign tile.skip_cols       = o_skip_q;
	assign tile.edge_horizontal = o_edge_h_q;
	assign tile.edge_vertical   = o_edge_v_q;
	assign tile.last_tile       = o_last_q;

endmodule

>>> hdl/btd_checker.sv
module btd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        tile_valid,
	input logic        tile_ready,
	input logic [11:0] tile_x,
	input logic        edge_h,
	input logic        last_tile
);

	// a stalled descriptor stays put
	a_tile_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tile_valid && !tile_ready |=> tile_valid && $stable(tile_x) && $stable(last_tile))
		else $error("tile descriptor changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while setup still running");

	// the row is still being tiled while a non-final descriptor is out
	a_busy_mid_row: assert property (@(posedge clk) disable iff (!arst_n)
		tile_valid && !last_tile |-> !req_ready)
		else $error("ready for a request before the row's last tile");

	a_left_edge: assert property (@(posedge clk) disable iff (!arst_n)
		tile_valid && tile_x == 12'd0 |-> edge_h)
		else $error("tile at column zero not flagged as picture edge");

endmodule

bind blend_tile_descriptor_generator btd_checker u_btd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.tile_valid (tile.valid),
	.tile_ready (tile.ready),
	.tile_x     (tile.tile_x),
	.edge_h     (tile.edge_horizontal),
	.last_tile  (tile.last_tile)
);
